// ===== sv/pip_pkg.sv =====
// pip_pkg: shared codes, state type and control/status bundles for the
// point-in-polygon crossing test. No dependencies.
`default_nettype none

package pip_pkg;

    // Request command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN
    } pip_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_we;   // write the request's vertex into its slot
        logic q_start;   // capture query point, clear parity and hit
        logic rd_en;     // read one vertex from the store
        logic rd_eval;   // the window after this read holds a full edge
        logic res_load;  // move the finished answer to the output register
    } pip_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pipe_busy; // an edge is still in flight
        logic out_free;  // output register can take a result this cycle
    } pip_sts_t;

endpackage

`default_nettype wire

// ===== sv/pip_ctrl.sv =====
// pip_ctrl: sequencer for load and query requests; walks the vertex store
// once per query. Depends on pip_pkg.
`default_nettype none

module pip_ctrl #(
    parameter int MAX_VERTICES = 16
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  wire                                  cmd,
    input  wire  [$clog2(MAX_VERTICES+1)-1:0]    n_vert,
    input  pip_pkg::pip_sts_t                    sts,
    output pip_pkg::pip_cmd_t                    ctl,
    output logic [$clog2(MAX_VERTICES)-1:0]      rd_addr
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int JW = $clog2(MAX_VERTICES + 2);

    pip_pkg::pip_state_t state_reg, state_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic [JW-1:0] jcnt_reg, jcnt_next;
    logic          accept;
    logic [AW-1:0] last_addr;

    assign accept    = in_valid && in_ready;
    assign last_addr = AW'(n_vert - NW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pip_pkg::ST_IDLE;
            rd_addr_reg <= '0;
            jcnt_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_addr_reg <= rd_addr_next;
            jcnt_reg    <= jcnt_next;
        end
    end

    // Next state and counters
    always_comb
    begin
        state_next   = state_reg;
        rd_addr_next = rd_addr_reg;
        jcnt_next    = jcnt_reg;
        case (state_reg)
            pip_pkg::ST_IDLE:
            begin
                if (accept && cmd == pip_pkg::CMD_QUERY)
                begin
                    // first read (last vertex) goes out this cycle, wrap to slot 0
                    rd_addr_next = '0;
                    jcnt_next    = JW'(1);
                    state_next   = (n_vert == '0) ? pip_pkg::ST_DRAIN : pip_pkg::ST_READ;
                end
            end
            pip_pkg::ST_READ:
            begin
                rd_addr_next = (rd_addr_reg == last_addr) ? '0 : rd_addr_reg + AW'(1);
                jcnt_next    = jcnt_reg + JW'(1);
                if (jcnt_reg == JW'(n_vert) + JW'(1))
                    state_next = pip_pkg::ST_DRAIN;
            end
            pip_pkg::ST_DRAIN:
            begin
                if (!sts.pipe_busy && sts.out_free)
                    state_next = pip_pkg::ST_IDLE;
            end
            default:
                state_next = pip_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready = 1'b0;
        ctl      = '0;
        rd_addr  = rd_addr_reg;
        case (state_reg)
            pip_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept && cmd == pip_pkg::CMD_LOAD)
                    ctl.load_we = 1'b1;
                if (accept && cmd == pip_pkg::CMD_QUERY)
                begin
                    ctl.q_start = 1'b1;
                    ctl.rd_en   = (n_vert != '0);
                    rd_addr     = last_addr;
                end
            end
            pip_pkg::ST_READ:
            begin
                ctl.rd_en   = 1'b1;
                ctl.rd_eval = (jcnt_reg >= JW'(2));
            end
            pip_pkg::ST_DRAIN:
                ctl.res_load = !sts.pipe_busy && sts.out_free;
            default:
                ctl = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/pip_dp.sv =====
// pip_dp: vertex store, three-vertex window, edge test pipeline, parity and
// output register. Depends on pip_pkg.
`default_nettype none

module pip_dp #(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_WIDTH  = 16
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  pip_pkg::pip_cmd_t                    ctl,
    output pip_pkg::pip_sts_t                    sts,
    input  wire  [$clog2(MAX_VERTICES)-1:0]      rd_addr,
    output logic [$clog2(MAX_VERTICES+1)-1:0]    n_vert,
    input  wire                                  cfg_we,
    input  wire  [4:0]                           cfg_wdata,
    input  wire  [3:0]                           vertex_index,
    input  wire  signed [COORD_WIDTH-1:0]        coord_x,
    input  wire  signed [COORD_WIDTH-1:0]        coord_y,
    input  wire                                  out_ready,
    output logic                                 out_valid,
    output logic                                 inside_res
);

    localparam int W  = COORD_WIDTH;
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);

    logic [4:0]       vertex_count_reg;
    logic [2*W-1:0]   mem [MAX_VERTICES];
    logic [2*W-1:0]   rd_data_reg;
    logic             rd_vld_reg, rd_tag_reg;

    logic signed [W-1:0] q_x_reg, q_y_reg;
    logic signed [W-1:0] prv_y_reg, cur_x_reg, cur_y_reg, nxt_x_reg, nxt_y_reg;
    logic                win_vld_reg;

    // stage 1: flags and differences
    logic                s1_vld_reg, s1_hit_reg, s1_cnt_reg, s1_mul_reg, s1_dypos_reg;
    logic signed [W:0]   s1_a_reg, s1_b_reg, s1_c_reg, s1_d_reg;
    logic                a_hit, a_cnt, a_mul, a_on_ray;
    // stage 2: products
    logic                s2_vld_reg, s2_hit_reg, s2_cnt_reg, s2_mul_reg, s2_dypos_reg;
    logic signed [2*W+1:0] s2_p_reg, s2_q_reg;
    logic                c_le, c_inc;

    logic parity_reg, hit_reg;
    logic out_valid_reg, inside_res_reg;
    logic in_range;

    // Clamp the vertex count to the store depth
    always_comb
    begin
        if (32'(vertex_count_reg) > 32'(MAX_VERTICES))
            n_vert = NW'(MAX_VERTICES);
        else
            n_vert = NW'(vertex_count_reg);
    end

    assign in_range = (32'(vertex_index) < 32'(MAX_VERTICES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vertex_count_reg <= '0;
        else if (cfg_we)
            vertex_count_reg <= cfg_wdata;
    end

    // Vertex store: one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (ctl.load_we && in_range)
            mem[AW'(vertex_index)] <= {coord_x, coord_y};
        if (ctl.rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Query point and sliding window
    always_ff @(posedge clk)
    begin
        if (ctl.q_start)
        begin
            q_x_reg <= coord_x;
            q_y_reg <= coord_y;
        end
        if (rd_vld_reg)
        begin
            prv_y_reg <= cur_y_reg;
            cur_x_reg <= nxt_x_reg;
            cur_y_reg <= nxt_y_reg;
            nxt_x_reg <= rd_data_reg[2*W-1:W];
            nxt_y_reg <= rd_data_reg[W-1:0];
        end
    end

    // Edge classification from the window
    always_comb
    begin
        a_on_ray = (cur_y_reg == q_y_reg) && (cur_x_reg <= q_x_reg);
        a_hit    = 1'b0;
        a_cnt    = 1'b0;
        a_mul    = 1'b0;
        if (a_on_ray)
        begin
            a_hit = (cur_x_reg == q_x_reg);
            a_cnt = !a_hit
                  && !((prv_y_reg > q_y_reg && nxt_y_reg > q_y_reg)
                    || (prv_y_reg < q_y_reg && nxt_y_reg < q_y_reg));
        end
        else
        begin
            a_mul = !((cur_y_reg > q_y_reg && nxt_y_reg >= q_y_reg)
                   || (cur_y_reg < q_y_reg && nxt_y_reg <= q_y_reg)
                   || (cur_x_reg > q_x_reg && nxt_x_reg > q_x_reg)
                   || (nxt_y_reg == cur_y_reg)
                   || (cur_y_reg == q_y_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        s1_hit_reg   <= a_hit;
        s1_cnt_reg   <= a_cnt;
        s1_mul_reg   <= a_mul;
        s1_dypos_reg <= (nxt_y_reg > cur_y_reg);
        s1_a_reg     <= (W+1)'(q_y_reg)   - (W+1)'(cur_y_reg);
        s1_b_reg     <= (W+1)'(nxt_x_reg) - (W+1)'(cur_x_reg);
        s1_c_reg     <= (W+1)'(q_x_reg)   - (W+1)'(cur_x_reg);
        s1_d_reg     <= (W+1)'(nxt_y_reg) - (W+1)'(cur_y_reg);

        s2_hit_reg   <= s1_hit_reg;
        s2_cnt_reg   <= s1_cnt_reg;
        s2_mul_reg   <= s1_mul_reg;
        s2_dypos_reg <= s1_dypos_reg;
        s2_p_reg     <= (2*W+2)'(s1_a_reg) * (2*W+2)'(s1_b_reg);
        s2_q_reg     <= (2*W+2)'(s1_c_reg) * (2*W+2)'(s1_d_reg);
    end

    // Crossing x left of or at the query x; sign of dy flips the compare
    assign c_le  = s2_dypos_reg ? (s2_p_reg <= s2_q_reg) : (s2_q_reg <= s2_p_reg);
    assign c_inc = s2_cnt_reg || (s2_mul_reg && c_le);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg     <= 1'b0;
            rd_tag_reg     <= 1'b0;
            win_vld_reg    <= 1'b0;
            s1_vld_reg     <= 1'b0;
            s2_vld_reg     <= 1'b0;
            parity_reg     <= 1'b0;
            hit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_vld_reg  <= ctl.rd_en;
            rd_tag_reg  <= ctl.rd_en && ctl.rd_eval;
            win_vld_reg <= rd_tag_reg;
            s1_vld_reg  <= win_vld_reg;
            s2_vld_reg  <= s1_vld_reg;
            if (ctl.q_start)
            begin
                parity_reg <= 1'b0;
                hit_reg    <= 1'b0;
            end
            else if (s2_vld_reg)
            begin
                parity_reg <= parity_reg ^ c_inc;
                hit_reg    <= hit_reg | s2_hit_reg;
            end
            if (ctl.res_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.res_load)
            inside_res_reg <= hit_reg | parity_reg;
    end

    assign sts.pipe_busy = rd_vld_reg || rd_tag_reg || win_vld_reg || s1_vld_reg || s2_vld_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign inside_res    = inside_res_reg;

endmodule

`default_nettype wire

// ===== sv/point_in_polygon_crossing_test.sv =====
// point_in_polygon_crossing_test: top level; joins the request sequencer and
// the edge-test datapath. Depends on pip_pkg, pip_ctrl, pip_dp.
//
//   channel   direction  signals                                   handshake
//   in        request    cmd, vertex_index, coord_x, coord_y       in_valid / in_ready
//   out       result     inside_res                                out_valid / out_ready
//   cfg       write      cfg_wdata (vertex_count)                  cfg_we, no wait
//
// A load request writes the vertex into its slot at acceptance.
// A query request with n >= 1 vertices in use reads the vertex store once per
// cycle, n + 2 reads starting in the acceptance cycle; then read data, window,
// compare setup and multiply/parity stages drain before the answer moves to the
// output register, and only then is the next request taken. The store's single
// read port sets the read pace. With no vertices in use no vertex is read and
// the answer moves to the output register once the pipeline is idle.
// A finished result waits in the output register; the next request is taken
// while it waits, and a later query holds its answer until the slot is free.
// Reset clears vertex_count and all control; the vertex store is not cleared.
`default_nettype none

module point_in_polygon_crossing_test #(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_WIDTH  = 16
) (
    input  wire                           clk,
    input  wire                           rst_n,
    // request channel
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire                           cmd,
    input  wire  [3:0]                    vertex_index,
    input  wire  signed [COORD_WIDTH-1:0] coord_x,
    input  wire  signed [COORD_WIDTH-1:0] coord_y,
    // result channel
    output logic                          out_valid,
    input  wire                           out_ready,
    output logic                          inside_res,
    // vertex_count register
    input  wire                           cfg_we,
    input  wire  [4:0]                    cfg_wdata
);

    pip_pkg::pip_cmd_t                   ctl;
    pip_pkg::pip_sts_t                   sts;
    logic [$clog2(MAX_VERTICES)-1:0]     rd_addr;
    logic [$clog2(MAX_VERTICES+1)-1:0]   n_vert;

    // Sequencer: accepts requests, walks slots n-1, 0, 1, ..., n-1, 0
    pip_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .n_vert   (n_vert),
        .sts      (sts),
        .ctl      (ctl),
        .rd_addr  (rd_addr)
    );

    // Datapath: store, window of previous/current/next vertex, exact
    // cross-multiplied crossing test, parity and output register
    pip_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sts          (sts),
        .rd_addr      (rd_addr),
        .n_vert       (n_vert),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .vertex_index (vertex_index),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .inside_res   (inside_res)
    );

endmodule

`default_nettype wire

// ===== sv/pip_checker.sv =====
// pip_checker: port-level assertions for the point-in-polygon block, bound to
// the top level. Depends on point_in_polygon_crossing_test and pip_pkg.
`default_nettype none

module pip_checker (
    input wire clk,
    input wire rst_n,
    input wire in_valid,
    input wire in_ready,
    input wire cmd,
    input wire out_valid,
    input wire out_ready,
    input wire inside_res
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(inside_res))
        else $error("result changed while stalled");

    // A load request produces no result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && cmd == pip_pkg::CMD_LOAD && !out_valid |=> !out_valid)
        else $error("load request produced a result");

    // A query request occupies the block
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && cmd == pip_pkg::CMD_QUERY |=> !in_ready)
        else $error("request taken while a query is running");

    // A new result appears only at the end of a running query
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without a running query");

endmodule

bind point_in_polygon_crossing_test pip_checker u_pip_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .inside_res (inside_res)
);

`default_nettype wire
